// ===== hw/rtl/etm_pkg.sv =====
package etm_pkg;

    localparam int unsigned PIXEL_W      = 8;
    localparam int unsigned LOGO_SIDE_W  = 5;
    localparam int unsigned IMAGE_SIDE_W = 10;
    localparam int unsigned CFG_W        = 10;

    typedef enum logic [0:0] {
        OP_LOGO_LOAD   = 1'b0,
        OP_IMAGE_PIXEL = 1'b1
    } t_op;

    typedef enum logic [0:0] {
        REG_LOGO_SIDE  = 1'b0,
        REG_IMAGE_SIDE = 1'b1
    } t_cfg_reg;

    // commands from the accept stage to the logo unit
    typedef struct packed {
        logic load;     // logo pixel accepted
        logic stream;   // image pixel accepted
        logic restart;  // register write: logo index back to zero
        logic remap;    // logo side written: rebuild the compare grid
    } t_logo_cmd;

    // image pixel entering the column stage
    typedef struct packed {
        logic valid;
        logic last;       // bottom-right pixel of the image
        logic first_row;  // no valid column history above this pixel
    } t_pix_ctl;

endpackage

// ===== hw/rtl/exact_template_match_2d.sv =====
// channel   direction  handshake           payload
// input     in         i_valid / o_ready   i_operation, i_pixel
// result    out        o_valid / i_ready   o_found
// config    in         i_cfg_we            i_cfg_idx, i_cfg_data
//
// One item a cycle while o_ready is high. After its last image pixel is accepted,
// a result passes the r_ctl stage and then the output register; the column-history
// RAM is read on acceptance, updated, and written back from r_ctl.
// Writing logo_side starts a remap that re-reads the stored logo into the compare
// grid, one logo entry a cycle through the logo RAM port, with o_ready low.
// Synchronous active-low reset; logo and column memories are not cleared.
// Besides a remap, input stalls only while a finished result is unread and the
// next image's last pixel is waiting behind it.
module exact_template_match_2d #(
    parameter int unsigned MAX_LOGO_SIDE  = 16,
    parameter int unsigned MAX_IMAGE_SIDE = 512
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  etm_pkg::t_op                i_operation,
    input  logic [etm_pkg::PIXEL_W-1:0] i_pixel,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic                        o_found,
    input  logic                        i_cfg_we,
    input  etm_pkg::t_cfg_reg           i_cfg_idx,
    input  logic [etm_pkg::CFG_W-1:0]   i_cfg_data
);

    import etm_pkg::*;

    localparam int unsigned LK_W  = (MAX_LOGO_SIDE > 1) ? $clog2(MAX_LOGO_SIDE) : 1;
    localparam int unsigned COL_W = (MAX_IMAGE_SIDE > 1) ? $clog2(MAX_IMAGE_SIDE) : 1;

    // effective sides, stored minus one
    logic [LK_W-1:0]  r_ls_m1;
    logic [COL_W-1:0] r_is_m1;
    logic [LK_W-1:0]  cfg_ls_m1;
    logic [COL_W-1:0] cfg_is_m1;
    logic [LOGO_SIDE_W-1:0]  cfg_ls;
    logic [IMAGE_SIDE_W-1:0] cfg_is;

    logic [COL_W-1:0] r_row;
    logic [COL_W-1:0] r_col;

    logic acc;
    logic pix_acc;
    logic load_acc;
    logic pix_last;
    logic col_ok;
    logic logo_busy;
    logic col_blocked;

    t_logo_cmd                logo_cmd;
    t_pix_ctl                 pix_ctl;
    logic [MAX_LOGO_SIDE-1:0] logo_rm;
    logic [MAX_LOGO_SIDE-1:0] col_rm;

    assign o_ready  = !logo_busy && !col_blocked;
    assign acc      = i_valid && o_ready;
    assign pix_acc  = acc && (i_operation == OP_IMAGE_PIXEL);
    assign load_acc = acc && (i_operation == OP_LOGO_LOAD);
    assign pix_last = (r_row == r_is_m1) && (r_col == r_is_m1);
    assign col_ok   = 32'(r_col) >= 32'(r_ls_m1);

    // zero acts as one, anything above the maximum as the maximum; the logo side uses only the low LOGO_SIDE_W bits
    assign cfg_ls = i_cfg_data[LOGO_SIDE_W-1:0];
    assign cfg_is = i_cfg_data[IMAGE_SIDE_W-1:0];

    always_comb begin
        if (cfg_ls == '0) begin
            cfg_ls_m1 = '0;
        end else if (32'(cfg_ls) > 32'(MAX_LOGO_SIDE)) begin
            cfg_ls_m1 = LK_W'(MAX_LOGO_SIDE - 1);
        end else begin
            cfg_ls_m1 = LK_W'(32'(cfg_ls) - 32'd1);
        end
        if (cfg_is == '0) begin
            cfg_is_m1 = '0;
        end else if (32'(cfg_is) > 32'(MAX_IMAGE_SIDE)) begin
            cfg_is_m1 = COL_W'(MAX_IMAGE_SIDE - 1);
        end else begin
            cfg_is_m1 = COL_W'(32'(cfg_is) - 32'd1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ls_m1 <= '0;
            r_is_m1 <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_LOGO_SIDE:  r_ls_m1 <= cfg_ls_m1;
                REG_IMAGE_SIDE: r_is_m1 <= cfg_is_m1;
                default: ;
            endcase
        end
    end

    // raster position of the next image pixel
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we || load_acc) begin
            r_row <= '0;
            r_col <= '0;
        end else if (pix_acc) begin
            if (pix_last) begin
                r_row <= '0;
                r_col <= '0;
            end else if (r_col == r_is_m1) begin
                r_col <= '0;
                r_row <= r_row + 1'b1;
            end else begin
                r_col <= r_col + 1'b1;
            end
        end
    end

    always_comb begin
        logo_cmd.load    = load_acc;
        logo_cmd.stream  = pix_acc;
        logo_cmd.restart = i_cfg_we;
        logo_cmd.remap   = i_cfg_we && (i_cfg_idx == REG_LOGO_SIDE);
        pix_ctl.valid     = pix_acc;
        pix_ctl.last      = pix_last;
        pix_ctl.first_row = (r_row == '0);
    end

    // a row segment only counts once it lies wholly inside the line
    assign col_rm = logo_rm & {MAX_LOGO_SIDE{col_ok}};

    etm_logo #(
        .MAX_LOGO_SIDE (MAX_LOGO_SIDE)
    ) u_logo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (logo_cmd),
        .i_pixel     (i_pixel),
        .i_ls_m1     (r_ls_m1),
        .o_busy      (logo_busy),
        .o_row_match (logo_rm)
    );

    etm_column #(
        .MAX_LOGO_SIDE  (MAX_LOGO_SIDE),
        .MAX_IMAGE_SIDE (MAX_IMAGE_SIDE)
    ) u_column (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (pix_ctl),
        .i_col       (r_col),
        .i_row_match (col_rm),
        .i_ls_m1     (r_ls_m1),
        .i_restart   (load_acc || i_cfg_we),
        .o_blocked   (col_blocked),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_found     (o_found)
    );

    a_pos_in_image: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_row <= r_is_m1) && (r_col <= r_is_m1))
        else $error("raster position outside the image");

    a_remap_holds_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_we && (i_cfg_idx == REG_LOGO_SIDE)) |=> !o_ready)
        else $error("item accepted while the logo grid is being rebuilt");

    a_cfg_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> (r_row == '0) && (r_col == '0))
        else $error("register write did not restart the image");

endmodule

// ===== hw/rtl/etm_ram.sv =====
module etm_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 256,
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/etm_logo.sv =====
module etm_logo #(
    parameter int unsigned MAX_LOGO_SIDE = 16,
    localparam int unsigned LK_W = (MAX_LOGO_SIDE > 1) ? $clog2(MAX_LOGO_SIDE) : 1,
    localparam int unsigned LA_W =
        (MAX_LOGO_SIDE > 1) ? $clog2(MAX_LOGO_SIDE * MAX_LOGO_SIDE) : 1
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  etm_pkg::t_logo_cmd           i_cmd,
    input  logic [etm_pkg::PIXEL_W-1:0]  i_pixel,
    input  logic [LK_W-1:0]              i_ls_m1,
    output logic                         o_busy,
    output logic [MAX_LOGO_SIDE-1:0]     o_row_match
);

    import etm_pkg::*;

    localparam int unsigned LOGO_DEPTH = MAX_LOGO_SIDE * MAX_LOGO_SIDE;

    // load position: logo row, column and flat index
    logic [LK_W-1:0] r_lrow;
    logic [LK_W-1:0] r_lcol;
    logic [LA_W-1:0] r_lidx;
    logic            load_wrap;

    // remap sweep: issue side and write side
    logic            r_sw_act;
    logic [LK_W-1:0] r_sw_row;
    logic [LK_W-1:0] r_sw_col;
    logic [LA_W-1:0] r_sw_idx;
    logic            sw_done;
    logic            r_sw_wr;
    logic [LK_W-1:0] r_sw_wr_row;
    logic [LK_W-1:0] r_sw_wr_j;
    logic [PIXEL_W-1:0] sw_rdata;

    // compare grid: row k, lane j counted from the newest pixel
    logic [PIXEL_W-1:0] r_grid [MAX_LOGO_SIDE][MAX_LOGO_SIDE];
    logic               g_we;
    logic [LK_W-1:0]    g_row;
    logic [LK_W-1:0]    g_j;
    logic [PIXEL_W-1:0] g_data;

    logic [PIXEL_W-1:0]       win [MAX_LOGO_SIDE];
    logic [MAX_LOGO_SIDE-1:0] lane_ok [MAX_LOGO_SIDE];

    assign load_wrap = (r_lrow == i_ls_m1) && (r_lcol == i_ls_m1);
    assign sw_done   = (r_sw_row == i_ls_m1) && (r_sw_col == i_ls_m1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.stream || i_cmd.restart) begin
            r_lrow <= '0;
            r_lcol <= '0;
            r_lidx <= '0;
        end else if (i_cmd.load) begin
            if (load_wrap) begin
                r_lrow <= '0;
                r_lcol <= '0;
                r_lidx <= '0;
            end else begin
                r_lidx <= r_lidx + 1'b1;
                if (r_lcol == i_ls_m1) begin
                    r_lcol <= '0;
                    r_lrow <= r_lrow + 1'b1;
                end else begin
                    r_lcol <= r_lcol + 1'b1;
                end
            end
        end
    end

    // flat store keeps the load order so a new side can re-read it
    etm_ram #(
        .WIDTH (PIXEL_W),
        .DEPTH (LOGO_DEPTH)
    ) u_logo_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.load),
        .i_waddr (r_lidx),
        .i_wdata (i_pixel),
        .i_re    (r_sw_act),
        .i_raddr (r_sw_idx),
        .o_rdata (sw_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sw_act <= 1'b0;
            r_sw_wr  <= 1'b0;
            r_sw_row <= '0;
            r_sw_col <= '0;
            r_sw_idx <= '0;
        end else begin
            r_sw_wr <= r_sw_act;
            if (i_cmd.remap) begin
                r_sw_act <= 1'b1;
                r_sw_row <= '0;
                r_sw_col <= '0;
                r_sw_idx <= '0;
            end else if (r_sw_act) begin
                r_sw_idx <= r_sw_idx + 1'b1;
                if (sw_done) begin
                    r_sw_act <= 1'b0;
                end else if (r_sw_col == i_ls_m1) begin
                    r_sw_col <= '0;
                    r_sw_row <= r_sw_row + 1'b1;
                end else begin
                    r_sw_col <= r_sw_col + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_sw_wr_row <= r_sw_row;
        r_sw_wr_j   <= i_ls_m1 - r_sw_col;
    end

    always_comb begin
        g_we = i_cmd.load || r_sw_wr;
        if (r_sw_wr) begin
            g_row  = r_sw_wr_row;
            g_j    = r_sw_wr_j;
            g_data = sw_rdata;
        end else begin
            g_row  = r_lrow;
            g_j    = i_ls_m1 - r_lcol;
            g_data = i_pixel;
        end
    end

    always_ff @(posedge i_clk) begin
        if (g_we) begin
            r_grid[g_row][g_j] <= g_data;
        end
    end

    assign o_busy = r_sw_act || r_sw_wr;

    // horizontal history of the current image line, newest first
    assign win[0] = i_pixel;

    generate
        if (MAX_LOGO_SIDE > 1) begin : g_hist
            logic [PIXEL_W-1:0] r_hist [MAX_LOGO_SIDE-1];

            always_ff @(posedge i_clk) begin
                if (i_cmd.stream) begin
                    r_hist[0] <= i_pixel;
                    for (int i = 1; i < MAX_LOGO_SIDE - 1; i++) begin
                        r_hist[i] <= r_hist[i-1];
                    end
                end
            end

            for (genvar j = 1; j < MAX_LOGO_SIDE; j++) begin : g_tap
                assign win[j] = r_hist[j-1];
            end
        end
    endgenerate

    // every logo row against the last logo_side pixels of the line
    always_comb begin
        for (int k = 0; k < MAX_LOGO_SIDE; k++) begin
            for (int j = 0; j < MAX_LOGO_SIDE; j++) begin
                lane_ok[k][j] = (win[j] == r_grid[k][j]) || (32'(j) > 32'(i_ls_m1));
            end
            o_row_match[k] = (&lane_ok[k]) && (32'(k) <= 32'(i_ls_m1));
        end
    end

endmodule

// ===== hw/rtl/etm_column.sv =====
module etm_column #(
    parameter int unsigned MAX_LOGO_SIDE  = 16,
    parameter int unsigned MAX_IMAGE_SIDE = 512,
    localparam int unsigned LK_W  = (MAX_LOGO_SIDE > 1) ? $clog2(MAX_LOGO_SIDE) : 1,
    localparam int unsigned COL_W = (MAX_IMAGE_SIDE > 1) ? $clog2(MAX_IMAGE_SIDE) : 1
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  etm_pkg::t_pix_ctl        i_ctl,
    input  logic [COL_W-1:0]         i_col,
    input  logic [MAX_LOGO_SIDE-1:0] i_row_match,
    input  logic [LK_W-1:0]          i_ls_m1,
    input  logic                     i_restart,
    output logic                     o_blocked,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic                     o_found
);

    import etm_pkg::*;

    t_pix_ctl                 r_ctl;
    logic [COL_W-1:0]         r_col;
    logic [MAX_LOGO_SIDE-1:0] r_rm;
    logic [MAX_LOGO_SIDE-1:0] v_old;
    logic [MAX_LOGO_SIDE-1:0] v_new;
    logic                     fire;
    logic                     hit;
    logic                     r_seen;
    logic                     r_out_valid;
    logic                     r_found;

    // a finished image waits while the previous result is still unread
    assign o_blocked = r_ctl.valid && r_ctl.last && r_out_valid && !i_ready;
    assign fire      = r_ctl.valid && !o_blocked;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_ctl.valid) begin
            r_ctl <= i_ctl;
        end else if (fire) begin
            r_ctl.valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.valid) begin
            r_col <= i_col;
            r_rm  <= i_row_match;
        end
    end

    // bit k of a column entry: logo rows 0..k match, ending on this line.
    // Same column read and written together only for a one-column image,
    // where every pixel is in the first row and the old entry is ignored.
    etm_ram #(
        .WIDTH (MAX_LOGO_SIDE),
        .DEPTH (MAX_IMAGE_SIDE)
    ) u_col_ram (
        .i_clk   (i_clk),
        .i_we    (fire),
        .i_waddr (r_col),
        .i_wdata (v_new),
        .i_re    (i_ctl.valid),
        .i_raddr (i_col),
        .o_rdata (v_old)
    );

    always_comb begin
        v_new[0] = r_rm[0];
        for (int k = 1; k < MAX_LOGO_SIDE; k++) begin
            v_new[k] = r_rm[k] && !r_ctl.first_row && v_old[k-1];
        end
    end

    assign hit = v_new[i_ls_m1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_restart) begin
            r_seen <= 1'b0;
        end else if (fire) begin
            r_seen <= r_ctl.last ? 1'b0 : (r_seen || hit);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire && r_ctl.last) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && r_ctl.last) begin
            r_found <= r_seen || hit;
        end
    end

    assign o_valid = r_out_valid;
    assign o_found = r_found;

endmodule
